@@ rtl/asu_pkg.sv @@
// ----------------------------------------------------------------------------
// asu_pkg: shared definitions for the Adam / SGD parameter update engine
// Holds the transaction types, register map, fixed-point limits and the
// sequencer states used across the update pipeline.
// ----------------------------------------------------------------------------
package asu_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int DECAY_BITS      = 16;
    localparam int SQRT_ITERATIONS = 32;
    localparam int SQRT_STEPS      = (SQRT_ITERATIONS > 32) ? 32 : SQRT_ITERATIONS;
    localparam int DIV_STEPS       = 64;
    localparam int CORR_ROUNDS     = 16;
    localparam int ROUND_W         = $clog2(CORR_ROUNDS);

    localparam logic [16:0] ONE_FIX   = 17'(64'd1 << FRAC_BITS);
    localparam logic [16:0] DECAY_ONE = 17'(64'd1 << DECAY_BITS);
    localparam logic [63:0] MHAT_MAX  = (64'd1 << 46) - 64'd1;
    localparam logic [63:0] VHAT_MAX  = (64'd1 << (62 - FRAC_BITS)) - 64'd1;
    localparam logic [63:0] DELTA_MAX = 64'd1 << 40;

    localparam int REG_COUNT = 7;
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_STEP   = 3'd1;
    localparam logic [2:0] REG_BETA1  = 3'd2;
    localparam logic [2:0] REG_BETA2  = 3'd3;
    localparam logic [2:0] REG_EPS    = 3'd4;
    localparam logic [2:0] REG_BATCH  = 3'd5;
    localparam logic [2:0] REG_TSTEP  = 3'd6;

    localparam logic        RST_MODE  = 1'b1;
    localparam logic [16:0] RST_STEP  = 17'd66;
    localparam logic [15:0] RST_BETA1 = 16'd58982;
    localparam logic [15:0] RST_BETA2 = 16'd65470;
    localparam logic [15:0] RST_EPS   = 16'd1;
    localparam logic [15:0] RST_BATCH = 16'd1;
    localparam logic [15:0] RST_TSTEP = 16'd1;

    typedef struct packed {
        logic signed [31:0] param_value;
        logic signed [31:0] grad_total;
        logic signed [31:0] moment_one;
        logic [30:0]        moment_two;
        logic               last_element;
    } item_t;

    typedef struct packed {
        logic signed [31:0] param_next;
        logic signed [31:0] moment_one_next;
        logic [30:0]        moment_two_next;
        logic               saturated;
        logic               last_out;
    } result_t;

    typedef struct packed {
        logic [31:0] param;
        logic [31:0] m_one;
        logic [30:0] m_two;
        logic [34:0] sgd_delta;
        logic [45:0] mhat_mag;
        logic        neg;
        logic        sat;
        logic        last;
    } side_t;

    typedef struct packed {
        logic [15:0] first_decay;
        logic [15:0] second_decay;
        logic [15:0] step_number;
    } corr_cfg_t;

    typedef enum logic [1:0] {
        CORR_IDLE,
        CORR_RUN,
        CORR_DONE
    } corr_state_t;

endpackage

@@ rtl/asu_corr.sv @@
// ----------------------------------------------------------------------------
// asu_corr: bias correction sequencer
// Forms 1-beta1^t and 1-beta2^t by square-and-multiply, one bit of t per
// cycle, after each register write.
// ----------------------------------------------------------------------------
module asu_corr
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  asu_pkg::corr_cfg_t cfg,
    output logic              busy,
    output logic [16:0]       correction_one,
    output logic [16:0]       correction_two
);
    import asu_pkg::*;

    corr_state_t state_reg, state_next;
    logic [ROUND_W-1:0] round_reg;
    logic [32:0] acc1_reg, acc2_reg;
    logic [31:0] base1_reg, base2_reg;
    logic [15:0] t_reg;
    logic [16:0] corr1_reg, corr2_reg;
    logic [64:0] acc1_prod, acc2_prod;
    logic [63:0] base1_prod, base2_prod;
    logic [32:0] diff1, diff2;

    assign acc1_prod  = {32'b0, acc1_reg} * {33'b0, base1_reg};
    assign acc2_prod  = {32'b0, acc2_reg} * {33'b0, base2_reg};
    assign base1_prod = {32'b0, base1_reg} * {32'b0, base1_reg};
    assign base2_prod = {32'b0, base2_reg} * {32'b0, base2_reg};
    assign diff1 = 33'h1_0000_0000 - acc1_reg;
    assign diff2 = 33'h1_0000_0000 - acc2_reg;

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b1;
        unique case (state_reg)
            CORR_IDLE:
            begin
                busy = 1'b0;
            end
            CORR_RUN:
            begin
                if (round_reg == ROUND_W'(CORR_ROUNDS - 1))
                begin
                    state_next = CORR_DONE;
                end
            end
            CORR_DONE:
            begin
                state_next = CORR_IDLE;
            end
            default:
            begin
                state_next = CORR_IDLE;
            end
        endcase
        if (start)
        begin
            state_next = CORR_RUN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORR_IDLE;
            round_reg <= '0;
            corr1_reg <= ONE_FIX;
            corr2_reg <= ONE_FIX;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == CORR_RUN && !start)
            begin
                round_reg <= round_reg + 1'b1;
            end
            else
            begin
                round_reg <= '0;
            end
            if (state_reg == CORR_DONE)
            begin
                corr1_reg <= (diff1[32:32-FRAC_BITS] == '0) ? 17'd1 : 17'(diff1[32:32-FRAC_BITS]);
                corr2_reg <= (diff2[32:32-FRAC_BITS] == '0) ? 17'd1 : 17'(diff2[32:32-FRAC_BITS]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc1_reg  <= 33'h1_0000_0000;
            acc2_reg  <= 33'h1_0000_0000;
            base1_reg <= {cfg.first_decay, 16'b0};
            base2_reg <= {cfg.second_decay, 16'b0};
            t_reg     <= cfg.step_number;
        end
        else if (state_reg == CORR_RUN)
        begin
            if (t_reg[round_reg])
            begin
                acc1_reg <= acc1_prod[64:32];
                acc2_reg <= acc2_prod[64:32];
            end
            base1_reg <= base1_prod[63:32];
            base2_reg <= base2_prod[63:32];
        end
    end

    assign correction_one = corr1_reg;
    assign correction_two = corr2_reg;

endmodule

@@ rtl/asu_div.sv @@
// ----------------------------------------------------------------------------
// asu_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, with the side data of each
// transaction carried alongside.
// ----------------------------------------------------------------------------
module asu_div
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [63:0]   num,
    input  logic [31:0]   den,
    input  asu_pkg::side_t in_side,
    output logic          out_valid,
    output logic [63:0]   quo,
    output asu_pkg::side_t out_side
);
    import asu_pkg::*;

    logic        valid_reg [DIV_STEPS];
    logic        valid_next [DIV_STEPS];
    logic [31:0] rem_reg [DIV_STEPS];
    logic [31:0] rem_next [DIV_STEPS];
    logic [63:0] nq_reg [DIV_STEPS];
    logic [63:0] nq_next [DIV_STEPS];
    logic [31:0] den_reg [DIV_STEPS];
    logic [31:0] den_next [DIV_STEPS];
    side_t       side_reg [DIV_STEPS];
    side_t       side_next [DIV_STEPS];

    always_comb
    begin
        logic [31:0] rem_in;
        logic [63:0] nq_in;
        logic [31:0] den_in;
        logic [33:0] trial;
        logic [33:0] diff;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            if (s == 0)
            begin
                rem_in        = '0;
                nq_in         = num;
                den_in        = den;
                valid_next[s] = in_valid;
                side_next[s]  = in_side;
            end
            else
            begin
                rem_in        = rem_reg[s-1];
                nq_in         = nq_reg[s-1];
                den_in        = den_reg[s-1];
                valid_next[s] = valid_reg[s-1];
                side_next[s]  = side_reg[s-1];
            end
            trial = {1'b0, rem_in, nq_in[63]};
            diff  = trial - {2'b00, den_in};
            rem_next[s] = diff[33] ? trial[31:0] : diff[31:0];
            nq_next[s]  = {nq_in[62:0], ~diff[33]};
            den_next[s] = den_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            nq_reg   <= nq_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign quo       = nq_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

@@ rtl/asu_sqrt.sv @@
// ----------------------------------------------------------------------------
// asu_sqrt: pipelined integer square root
// Digit-by-digit root, one result bit per stage, with side data carried.
// ----------------------------------------------------------------------------
module asu_sqrt
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [63:0]   radicand,
    input  asu_pkg::side_t in_side,
    output logic          out_valid,
    output logic [31:0]   root,
    output asu_pkg::side_t out_side
);
    import asu_pkg::*;

    logic        valid_reg [SQRT_STEPS];
    logic        valid_next [SQRT_STEPS];
    logic [63:0] op_reg [SQRT_STEPS];
    logic [63:0] op_next [SQRT_STEPS];
    logic [63:0] res_reg [SQRT_STEPS];
    logic [63:0] res_next [SQRT_STEPS];
    side_t       side_reg [SQRT_STEPS];
    side_t       side_next [SQRT_STEPS];

    always_comb
    begin
        logic [63:0] op_in;
        logic [63:0] res_in;
        logic [63:0] one;
        logic [63:0] trial;
        for (int s = 0; s < SQRT_STEPS; s++)
        begin
            if (s == 0)
            begin
                op_in         = radicand;
                res_in        = '0;
                valid_next[s] = in_valid;
                side_next[s]  = in_side;
            end
            else
            begin
                op_in         = op_reg[s-1];
                res_in        = res_reg[s-1];
                valid_next[s] = valid_reg[s-1];
                side_next[s]  = side_reg[s-1];
            end
            one   = 64'd1 << (2 * (SQRT_STEPS - 1 - s));
            trial = res_in | one;
            if (op_in >= trial)
            begin
                op_next[s]  = op_in - trial;
                res_next[s] = (res_in >> 1) | one;
            end
            else
            begin
                op_next[s]  = op_in;
                res_next[s] = res_in >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SQRT_STEPS; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg   <= op_next;
            res_reg  <= res_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign root      = res_reg[SQRT_STEPS-1][31:0];
    assign out_side  = side_reg[SQRT_STEPS-1];

endmodule

@@ rtl/adam_sgd_parameter_update.sv @@
// ----------------------------------------------------------------------------
// adam_sgd_parameter_update: per-element Adam / SGD optimiser engine
// Streams parameters with their gradients and moments through a fully
// pipelined update and returns the new parameter and moments.
// ----------------------------------------------------------------------------
// Items arrive on the item channel (valid/ready) and results leave on the
// result channel in the same order, one result per item. A transaction can
// be accepted on every cycle while the receiver keeps up and the corrections
// are not being recomputed, so the sustained rate is one item per clock.
// The update runs through four bit-serial divider pipelines of 64 stages
// each, a 32-stage square root and ten arithmetic stages.
// The registers are to be written over the APB port only while the engine is
// empty; the block itself does not enforce this. After each register write the
// bias corrections are recomputed; item_ready stays low until they are ready.
// Reset empties the pipeline and restores the register defaults, with both
// corrections at one. When the receiver stalls, the whole pipeline holds and
// item_ready falls; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module adam_sgd_parameter_update
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  asu_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output asu_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import asu_pkg::*;

    logic        mode_reg;
    logic [16:0] step_reg;
    logic [15:0] beta1_reg, beta2_reg, eps_reg, batch_reg, tstep_reg;
    logic        start_reg;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic        corr_busy;
    logic [16:0] corr_one, corr_two;
    corr_cfg_t   corr_cfg;
    logic        adv, accept;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= RST_MODE;
            step_reg  <= RST_STEP;
            beta1_reg <= RST_BETA1;
            beta2_reg <= RST_BETA2;
            eps_reg   <= RST_EPS;
            batch_reg <= RST_BATCH;
            tstep_reg <= RST_TSTEP;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= cfg_write && (cfg_index < 3'(REG_COUNT));
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_MODE:  mode_reg  <= pwdata[0];
                    REG_STEP:  step_reg  <= pwdata[16:0];
                    REG_BETA1: beta1_reg <= pwdata[15:0];
                    REG_BETA2: beta2_reg <= pwdata[15:0];
                    REG_EPS:   eps_reg   <= pwdata[15:0];
                    REG_BATCH: batch_reg <= pwdata[15:0];
                    REG_TSTEP: tstep_reg <= pwdata[15:0];
                    default:   ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_MODE:  prdata = {31'b0, mode_reg};
            REG_STEP:  prdata = {15'b0, step_reg};
            REG_BETA1: prdata = {16'b0, beta1_reg};
            REG_BETA2: prdata = {16'b0, beta2_reg};
            REG_EPS:   prdata = {16'b0, eps_reg};
            REG_BATCH: prdata = {16'b0, batch_reg};
            REG_TSTEP: prdata = {16'b0, tstep_reg};
            default:   prdata = '0;
        endcase
    end

    assign corr_cfg = '{first_decay: beta1_reg, second_decay: beta2_reg,
                        step_number: tstep_reg};

    asu_corr u_corr
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start_reg),
        .cfg            (corr_cfg),
        .busy           (corr_busy),
        .correction_one (corr_one),
        .correction_two (corr_two)
    );

    logic result_valid_reg;
    result_t result_reg;

    assign adv        = ~result_valid_reg | result_ready;
    assign item_ready = adv & ~corr_busy & ~start_reg;
    assign accept     = item_valid & item_ready;

    // Gradient divided by batch size.
    logic [31:0] grad_mag;
    logic [15:0] batch_div;
    side_t       in_side;
    logic        dg_valid;
    logic [63:0] dg_quo;
    side_t       dg_side;

    assign grad_mag  = item.grad_total[31] ? (~item.grad_total + 32'd1) : item.grad_total;
    assign batch_div = (batch_reg == '0) ? 16'd1 : batch_reg;

    always_comb
    begin
        in_side       = '0;
        in_side.param = item.param_value;
        in_side.m_one = item.moment_one;
        in_side.m_two = item.moment_two;
        in_side.neg   = item.grad_total[31];
        in_side.last  = item.last_element;
    end

    asu_div u_div_grad
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (accept),
        .num       ({32'b0, grad_mag}),
        .den       ({16'b0, batch_div}),
        .in_side   (in_side),
        .out_valid (dg_valid),
        .quo       (dg_quo),
        .out_side  (dg_side)
    );

    // Stage A: products.
    logic signed [32:0] g_val;
    logic [16:0] w1, w2;
    logic signed [48:0] a_bm_next;
    logic signed [50:0] a_wg_next, a_sg_next;
    logic a_valid_reg;
    side_t a_side_reg;
    logic signed [48:0] a_bm_reg;
    logic signed [50:0] a_wg_reg, a_sg_reg;
    logic [63:0] a_gg_reg;
    logic [46:0] a_bv_reg;

    assign w1    = DECAY_ONE - {1'b0, beta1_reg};
    assign w2    = DECAY_ONE - {1'b0, beta2_reg};
    assign g_val = dg_side.neg ? -$signed({1'b0, dg_quo[31:0]}) : $signed({1'b0, dg_quo[31:0]});
    assign a_bm_next = $signed({1'b0, beta1_reg}) * $signed(dg_side.m_one);
    assign a_wg_next = $signed({1'b0, w1}) * g_val;
    assign a_sg_next = $signed({1'b0, step_reg}) * g_val;

    // Stage B: first moment and squared gradient.
    logic signed [50:0] m_sum, m_fl, sgd_fl;
    logic [47:0] g2_full;
    logic m_sat, g2_sat;
    side_t b_side_next;
    logic b_valid_reg;
    side_t b_side_reg;
    logic [30:0] b_g2_reg;
    logic [46:0] b_bv_reg;

    assign m_sum   = 51'(a_bm_reg) + a_wg_reg;
    assign m_fl    = m_sum >>> DECAY_BITS;
    assign sgd_fl  = a_sg_reg >>> FRAC_BITS;
    assign g2_full = a_gg_reg[63:FRAC_BITS];
    assign m_sat   = (m_fl > 51'sd2147483647) || (m_fl < -51'sd2147483648);
    assign g2_sat  = g2_full[47:31] != '0;

    always_comb
    begin
        b_side_next = a_side_reg;
        b_side_next.sgd_delta = sgd_fl[34:0];
        if (mode_reg)
        begin
            if (m_sat)
            begin
                b_side_next.m_one = m_fl[50] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else
            begin
                b_side_next.m_one = m_fl[31:0];
            end
            b_side_next.sat = a_side_reg.sat | m_sat | g2_sat;
        end
    end

    // Stage C: weighted squared gradient.
    logic c_valid_reg;
    side_t c_side_reg;
    logic [47:0] c_wv_reg;
    logic [46:0] c_bv_reg;

    // Stage D: second moment and first-moment magnitude.
    logic [48:0] v_sum;
    side_t d_side_next;
    logic d_valid_reg;
    side_t d_side_reg;
    logic [31:0] d_mmag_reg;

    assign v_sum = {2'b0, c_bv_reg} + {1'b0, c_wv_reg};

    always_comb
    begin
        d_side_next     = c_side_reg;
        d_side_next.neg = c_side_reg.m_one[31];
        if (mode_reg)
        begin
            d_side_next.m_two = v_sum[DECAY_BITS+30:DECAY_BITS];
        end
    end

    logic dm_valid;
    logic [63:0] dm_quo;
    side_t dm_side;

    asu_div u_div_mhat
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d_valid_reg),
        .num       ({32'b0, d_mmag_reg} << FRAC_BITS),
        .den       ({15'b0, corr_one}),
        .in_side   (d_side_reg),
        .out_valid (dm_valid),
        .quo       (dm_quo),
        .out_side  (dm_side)
    );

    // Stage E: clamp of the corrected first moment.
    logic mhat_sat;
    side_t e_side_next;
    logic e_valid_reg;
    side_t e_side_reg;

    assign mhat_sat = dm_quo > MHAT_MAX;

    always_comb
    begin
        e_side_next          = dm_side;
        e_side_next.mhat_mag = mhat_sat ? MHAT_MAX[45:0] : dm_quo[45:0];
        e_side_next.sat      = dm_side.sat | (mode_reg & mhat_sat);
    end

    logic dv_valid;
    logic [63:0] dv_quo;
    side_t dv_side;

    asu_div u_div_vhat
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (e_valid_reg),
        .num       ({33'b0, e_side_reg.m_two} << FRAC_BITS),
        .den       ({15'b0, corr_two}),
        .in_side   (e_side_reg),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .out_side  (dv_side)
    );

    // Stage F: clamp of the corrected second moment.
    logic vhat_sat;
    logic [63:0] vhat;
    side_t f_side_next;
    logic f_valid_reg;
    side_t f_side_reg;
    logic [63:0] f_x_reg;

    assign vhat_sat = dv_quo > VHAT_MAX;
    assign vhat     = vhat_sat ? VHAT_MAX : dv_quo;

    always_comb
    begin
        f_side_next     = dv_side;
        f_side_next.sat = dv_side.sat | (mode_reg & vhat_sat);
    end

    logic sq_valid;
    logic [31:0] sq_root;
    side_t sq_side;

    asu_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid_reg),
        .radicand  (f_x_reg),
        .in_side   (f_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // Stage G: denominator and partial products of the step.
    logic [32:0] denom_sum;
    logic g_valid_reg;
    side_t g_side_reg;
    logic [31:0] g_den_reg;
    logic [39:0] g_pl_reg, g_ph_reg;

    assign denom_sum = {1'b0, sq_root} + {17'b0, eps_reg};

    // Stage H: full step product.
    logic h_valid_reg;
    side_t h_side_reg;
    logic [31:0] h_den_reg;
    logic [62:0] h_prod_reg;

    logic dd_valid;
    logic [63:0] dd_quo;
    side_t dd_side;

    asu_div u_div_delta
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (h_valid_reg),
        .num       ({1'b0, h_prod_reg}),
        .den       (h_den_reg),
        .in_side   (h_side_reg),
        .out_valid (dd_valid),
        .quo       (dd_quo),
        .out_side  (dd_side)
    );

    // Stage I: signed step, clamped in Adam mode.
    logic [40:0] d_mag;
    logic signed [41:0] adam_delta;
    logic i_valid_reg;
    side_t i_side_reg;
    logic signed [41:0] i_delta_reg;

    assign d_mag      = (dd_quo > DELTA_MAX) ? DELTA_MAX[40:0] : dd_quo[40:0];
    assign adam_delta = dd_side.neg ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});

    // Final stage: parameter step into the output register.
    logic signed [42:0] p_diff;
    logic p_sat;

    assign p_diff = 43'($signed(i_side_reg.param)) - 43'(i_delta_reg);
    assign p_sat  = (p_diff > 43'sd2147483647) || (p_diff < -43'sd2147483648);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            c_valid_reg      <= 1'b0;
            d_valid_reg      <= 1'b0;
            e_valid_reg      <= 1'b0;
            f_valid_reg      <= 1'b0;
            g_valid_reg      <= 1'b0;
            h_valid_reg      <= 1'b0;
            i_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg      <= dg_valid;
            b_valid_reg      <= a_valid_reg;
            c_valid_reg      <= b_valid_reg;
            d_valid_reg      <= c_valid_reg;
            e_valid_reg      <= dm_valid;
            f_valid_reg      <= dv_valid;
            g_valid_reg      <= sq_valid;
            h_valid_reg      <= g_valid_reg;
            i_valid_reg      <= dd_valid;
            result_valid_reg <= i_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg <= dg_side;
            a_bm_reg   <= a_bm_next;
            a_wg_reg   <= a_wg_next;
            a_sg_reg   <= a_sg_next;
            a_gg_reg   <= {32'b0, dg_quo[31:0]} * {32'b0, dg_quo[31:0]};
            a_bv_reg   <= {31'b0, beta2_reg} * {16'b0, dg_side.m_two};

            b_side_reg <= b_side_next;
            b_g2_reg   <= g2_sat ? 31'h7FFF_FFFF : g2_full[30:0];
            b_bv_reg   <= a_bv_reg;

            c_side_reg <= b_side_reg;
            c_wv_reg   <= {31'b0, w2} * {17'b0, b_g2_reg};
            c_bv_reg   <= b_bv_reg;

            d_side_reg <= d_side_next;
            d_mmag_reg <= c_side_reg.m_one[31] ? (~c_side_reg.m_one + 32'd1) : c_side_reg.m_one;

            e_side_reg <= e_side_next;

            f_side_reg <= f_side_next;
            f_x_reg    <= vhat << FRAC_BITS;

            g_side_reg <= sq_side;
            g_den_reg  <= (denom_sum == '0) ? 32'd1 : denom_sum[31:0];
            g_pl_reg   <= {23'b0, step_reg} * {17'b0, sq_side.mhat_mag[22:0]};
            g_ph_reg   <= {23'b0, step_reg} * {17'b0, sq_side.mhat_mag[45:23]};

            h_side_reg <= g_side_reg;
            h_den_reg  <= g_den_reg;
            h_prod_reg <= {g_ph_reg[39:0], 23'b0} + {23'b0, g_pl_reg};

            i_side_reg  <= dd_side;
            i_delta_reg <= mode_reg ? adam_delta : 42'($signed(dd_side.sgd_delta));

            result_reg.param_next      <= p_sat ? (p_diff[42] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                                : p_diff[31:0];
            result_reg.moment_one_next <= i_side_reg.m_one;
            result_reg.moment_two_next <= i_side_reg.m_two;
            result_reg.saturated       <= i_side_reg.sat | p_sat;
            result_reg.last_out        <= i_side_reg.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ rtl/asu_checker.sv @@
// ----------------------------------------------------------------------------
// asu_checker: port-level checks for the parameter update engine
// Watches the handshakes and the register port of the top level.
// ----------------------------------------------------------------------------
module asu_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input asu_pkg::result_t result,
    input logic             psel,
    input logic             penable,
    input logic             pwrite,
    input logic [4:0]       paddr
);
    import asu_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("Result withdrawn before its transaction completed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("Result payload changed while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> (!result_valid || result_ready))
        else $error("Item accepted while the pipeline is held.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[4:2] != 3'(REG_COUNT))) |=> !item_ready)
        else $error("Items accepted before the corrections were recomputed.");

endmodule

bind adam_sgd_parameter_update asu_checker u_asu_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr)
);

@@ sim/adam_sgd_parameter_update_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the Adam / SGD parameter update engine
// Streams directed and random elements through the engine under a series of
// register settings, predicts every result with an independent model of the
// fixed-point update and checks each result transaction field by field,
// with random idling on both channels and one long receiver stall.
// ----------------------------------------------------------------------------
module adam_sgd_parameter_update_test;

    import asu_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int STALL_CYCLES   = 700;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    item_t       item = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    adam_sgd_parameter_update u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Register copies and bias corrections of the predictor.
    logic        mode_q = RST_MODE;
    logic [16:0] lr_q = RST_STEP;
    logic [15:0] beta1_q = RST_BETA1;
    logic [15:0] beta2_q = RST_BETA2;
    logic [15:0] eps_q = RST_EPS;
    logic [15:0] batch_q = RST_BATCH;
    logic [15:0] tstep_q = RST_TSTEP;
    logic [31:0] corr1_q = 32'(ONE_FIX);
    logic [31:0] corr2_q = 32'(ONE_FIX);

    item_t   pending_items[$];
    result_t expected_results[$];
    int      errors = 0;
    int      results_seen = 0;
    int      idle_cycles = 0;
    int      tx_gap = 0;
    int      rx_gap = 0;
    int      stall_left = 0;
    bit      stall_done = 1'b0;
    bit      busy_sender = 1'b0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] bias_correction(logic [15:0] decay, logic [15:0] t);
        longint unsigned base;
        longint unsigned acc;
        longint unsigned c;
        base = longint'(decay) << 16;
        acc = 64'd1 << 32;
        for (int i = 0; i < 16; i++)
        begin
            if (t[i])
                acc = (acc * base) >> 32;
            base = (base * base) >> 32;
        end
        c = ((64'd1 << 32) - acc) >> (32 - FRAC_BITS);
        return (c == 0) ? 32'd1 : 32'(c);
    endfunction

    function automatic longint clamp32(longint x, inout bit sat);
        if (x > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic longint unsigned root_of(longint unsigned x);
        longint unsigned r;
        longint unsigned cand;
        r = 0;
        for (int b = SQRT_STEPS - 1; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            if (cand * cand <= x)
                r = cand;
        end
        return r;
    endfunction

    function automatic result_t predict_update(item_t it);
        result_t         r;
        bit              sat;
        longint          p, g, m, v, div, delta, m_out, v_out, b1, b2, m_hat, denom;
        longint unsigned g2, v_hat;
        sat = 1'b0;
        p = longint'(it.param_value);
        m = longint'(it.moment_one);
        v = longint'({1'b0, it.moment_two});
        div = (batch_q == 0) ? 1 : longint'({1'b0, batch_q});
        g = longint'(it.grad_total) / div;
        m_out = m;
        v_out = v;
        if (mode_q == 1'b0)
        begin
            delta = (longint'({1'b0, lr_q}) * g) >>> FRAC_BITS;
        end
        else
        begin
            b1 = longint'({1'b0, beta1_q});
            b2 = longint'({1'b0, beta2_q});
            g2 = longint'(g * g) >> FRAC_BITS;
            if (g2 > 64'h7FFF_FFFF)
            begin
                g2 = 64'h7FFF_FFFF;
                sat = 1'b1;
            end
            m_out = clamp32((b1 * m + (65536 - b1) * g) >>> 16, sat);
            v_out = (b2 * v + (65536 - b2) * longint'(g2)) >>> 16;
            m_hat = (m_out <<< FRAC_BITS) / longint'({1'b0, corr1_q});
            v_hat = (longint'(v_out) << FRAC_BITS) / longint'({1'b0, corr2_q});
            if (v_hat > VHAT_MAX)
            begin
                v_hat = VHAT_MAX;
                sat = 1'b1;
            end
            if (m_hat > longint'(MHAT_MAX))
            begin
                m_hat = longint'(MHAT_MAX);
                sat = 1'b1;
            end
            if (m_hat < -longint'(MHAT_MAX))
            begin
                m_hat = -longint'(MHAT_MAX);
                sat = 1'b1;
            end
            denom = longint'(root_of(v_hat << FRAC_BITS)) + longint'({1'b0, eps_q});
            if (denom == 0)
                denom = 1;
            delta = (longint'({1'b0, lr_q}) * m_hat) / denom;
        end
        if (delta > longint'(DELTA_MAX))
            delta = longint'(DELTA_MAX);
        if (delta < -longint'(DELTA_MAX))
            delta = -longint'(DELTA_MAX);
        p = clamp32(p - delta, sat);
        r.param_next = 32'(p);
        r.moment_one_next = 32'(m_out);
        r.moment_two_next = 31'(v_out);
        r.saturated = sat;
        r.last_out = it.last_element;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got, want);
        errors++;
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MODE:  mode_q = value[0];
            REG_STEP:  lr_q = value[16:0];
            REG_BETA1: beta1_q = value[15:0];
            REG_BETA2: beta2_q = value[15:0];
            REG_EPS:   eps_q = value[15:0];
            REG_BATCH: batch_q = value[15:0];
            REG_TSTEP: tstep_q = value[15:0];
            default:   ;
        endcase
        corr1_q = bias_correction(beta1_q, tstep_q);
        corr2_q = bias_correction(beta2_q, tstep_q);
    endtask

    task automatic configure(logic mode, logic [16:0] lr, logic [15:0] b1, logic [15:0] b2,
                             logic [15:0] eps, logic [15:0] batch, logic [15:0] t);
        write_register(REG_MODE, 32'(mode));
        write_register(REG_STEP, 32'(lr));
        write_register(REG_BETA1, 32'(b1));
        write_register(REG_BETA2, 32'(b2));
        write_register(REG_EPS, 32'(eps));
        write_register(REG_BATCH, 32'(batch));
        write_register(REG_TSTEP, 32'(t));
    endtask

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        case ($urandom_range(0, 5))
            0:       w = $urandom;
            1:       w = $urandom >> $urandom_range(0, 31);
            2:       w = -($urandom >> $urandom_range(0, 31));
            3:       w = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: w = $urandom >> $urandom_range(8, 24);
        endcase
        if ($urandom_range(0, 4) == 0)
            w = -w;
        return w;
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.param_value = random_word();
        it.grad_total = random_word();
        it.moment_one = random_word();
        it.moment_two = 31'(($urandom_range(0, 3) == 0) ? $urandom :
                            ($urandom >> $urandom_range(1, 31)));
        it.last_element = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    function automatic item_t make_item(logic [31:0] p, logic [31:0] g, logic [31:0] m,
                                        logic [30:0] v, logic last);
        item_t it;
        it.param_value = p;
        it.grad_total = g;
        it.moment_one = m;
        it.moment_two = v;
        it.last_element = last;
        return it;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_directed();
        pending_items.push_back(make_item(32'h0001_0000, 32'h0000_8000, 32'h0, 31'h0, 1'b0));
        pending_items.push_back(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                          31'h7FFF_FFFF, 1'b1));
        pending_items.push_back(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          31'h7FFF_FFFF, 1'b0));
        pending_items.push_back(make_item(32'h0, 32'h0, 32'h0, 31'h0, 1'b1));
        pending_items.push_back(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          31'h1, 1'b0));
        pending_items.push_back(make_item(32'h8000_0000, 32'h0100_0000, 32'h0, 31'h0, 1'b0));
        pending_items.push_back(make_item(32'h7FFF_FFFF, 32'hFF00_0000, 32'h0, 31'h0, 1'b1));
    endtask

    task automatic push_random(int count);
        for (int i = 0; i < count; i++)
            pending_items.push_back(random_item());
    endtask

    // Driver: one gap is drawn per transaction; some phases run without gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!(item_valid && !item_ready))
        begin
            if (item_valid)
                expected_results.push_back(predict_update(item));
            if (tx_gap > 0)
            begin
                tx_gap <= tx_gap - 1;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                item <= pending_items.pop_front();
                item_valid <= 1'b1;
                tx_gap <= busy_sender ? 0 :
                          (($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0);
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transaction and paces result_ready.
    always @(posedge clk)
    begin
        result_t want;
        int      gap;
        logic    rdy;
        if (rst_n)
        begin
            rdy = result_ready;
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", result.param_next, 32'h0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.param_next !== want.param_next)
                        report_mismatch("param_next", result.param_next, want.param_next);
                    if (result.moment_one_next !== want.moment_one_next)
                        report_mismatch("moment_one_next", result.moment_one_next,
                                        want.moment_one_next);
                    if (result.moment_two_next !== want.moment_two_next)
                        report_mismatch("moment_two_next", 32'(result.moment_two_next),
                                        32'(want.moment_two_next));
                    if (result.saturated !== want.saturated)
                        report_mismatch("saturated", 32'(result.saturated),
                                        32'(want.saturated));
                    if (result.last_out !== want.last_out)
                        report_mismatch("last_out", 32'(result.last_out), 32'(want.last_out));
                end
                gap = busy_sender ? 0 :
                      (($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0);
                rx_gap <= gap;
                rdy = (gap == 0);
                if (results_seen == 400 && !stall_done)
                begin
                    stall_done <= 1'b1;
                    stall_left <= STALL_CYCLES;
                    rdy = 1'b0;
                end
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rdy = 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap <= rx_gap - 1;
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
            end
            result_ready <= rdy;
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        push_directed();
        wait_idle();

        configure(1'b0, 17'd65536, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1);
        push_directed();
        wait_idle();
        configure(1'b1, 17'd65536, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd0);
        push_directed();
        wait_idle();
        configure(1'b1, 17'd0, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd65535);
        push_directed();
        wait_idle();

        // Long run without gaps while the receiver stalls, so the input backs up.
        configure(1'b1, RST_STEP, RST_BETA1, RST_BETA2, RST_EPS, 16'd4, 16'd10);
        busy_sender = 1'b1;
        push_random(500);
        wait_idle();
        busy_sender = 1'b0;

        for (int ph = 0; ph < 7; ph++)
        begin
            configure(logic'($urandom_range(0, 1)), 17'($urandom_range(0, 65536)),
                      16'($urandom), 16'($urandom_range(60000, 65535)),
                      16'($urandom_range(1, 65535) >> $urandom_range(0, 15)),
                      16'($urandom_range(1, 64)), 16'($urandom_range(1, 65535) >>
                                                      $urandom_range(0, 15)));
            push_random(200);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/asu_pkg.sv
rtl/asu_corr.sv
rtl/asu_div.sv
rtl/asu_sqrt.sv
rtl/adam_sgd_parameter_update.sv
rtl/asu_checker.sv
sim/adam_sgd_parameter_update_test.sv
